@@ rtl/core/gfca_pkg.sv @@
// Shared constants and types for the gated frequency counter with auto-ranging.
// Used by gated_frequency_counter_autorange_unit; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gfca_pkg;

	localparam int COUNT_BITS_DEF = 32;

	localparam logic [31:0] GATE_CYCLES_RESET = 32'd16000000;
	localparam logic [7:0]  PRESCALE_RESET    = 8'd8;

	localparam int unsigned KILO = 1000;
	localparam int unsigned MEGA = 1000000;

	// floor(2^32 / 125) and floor(2^24 / 125): divide by 1000 as (x >> 3) / 125
	localparam logic [25:0] RECIP125_HI = 26'd34359738;
	localparam logic [17:0] RECIP125_LO = 18'd134217;

	// configuration register indexes
	localparam logic [0:0] REG_GATE_CYCLES = 1'b0;
	localparam logic [0:0] REG_PRESCALE    = 1'b1;

	typedef enum logic [1:0] {
		UNIT_HZ  = 2'd0,
		UNIT_KHZ = 2'd1,
		UNIT_MHZ = 2'd2
	} unit_t;

endpackage

`default_nettype wire

@@ rtl/core/gated_frequency_counter_autorange_unit.sv @@
// Gated frequency counter: edge counting, gate timing, scaling, range and BCD pipeline.
// Depends on gfca_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One input word per reference clock cycle while s_tready is high. Bit 0 of s_tdata
// flags a rising edge of the measured signal. Edges are counted over gate_cycles
// accepted words (config index 0, zero acts as one); the word that closes a gate
// counts toward it and starts an 11-stage result pipeline (scale by
// prescale_multiplier at config index 1, saturate, divide by 1000 twice through
// reciprocal multiply and correct, then split into BCD digits). Stages advance
// independently, so bubbles collapse while m_tready is low; s_tready drops only
// when a gate-closing word arrives and the first stage is full and stalled.
// cfg_ready is always high.
module gated_frequency_counter_autorange_unit #(
	parameter int COUNT_BITS = gfca_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] signal_edge
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] frequency, [47:32] whole_bcd,
	                                    // [59:48] fraction_bcd
	output logic [2:0]       m_tuser,   // [1:0] unit, [2] overflow
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int NS = 11;
	localparam int PW = (COUNT_BITS + 8 > 33) ? COUNT_BITS + 8 : 33;

	// configuration
	logic [31:0] gate_cycles_q;
	logic [7:0]  prescale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_cycles_q <= gfca_pkg::GATE_CYCLES_RESET;
			prescale_q    <= gfca_pkg::PRESCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gfca_pkg::REG_GATE_CYCLES: gate_cycles_q <= cfg_data;
				gfca_pkg::REG_PRESCALE:    prescale_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// gate and edge counters
	logic [COUNT_BITS-1:0] edge_total_q;
	logic                  edge_sat_q;
	logic [31:0]           gate_elapsed_q;
	logic [31:0]           limit;
	logic [31:0]           elapsed_nxt;
	logic                  gate_end;
	logic [COUNT_BITS-1:0] edge_nxt;
	logic                  sat_nxt;
	logic                  in_acc;
	logic                  sig_edge;

	// stage valids, index 0 is stage 1
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	assign sig_edge    = s_tdata[0];
	assign limit       = (gate_cycles_q == '0) ? 32'd1 : gate_cycles_q;
	assign elapsed_nxt = (gate_elapsed_q == '1) ? gate_elapsed_q : gate_elapsed_q + 32'd1;
	assign gate_end    = elapsed_nxt >= limit;
	assign edge_nxt    = (sig_edge && edge_total_q != '1) ? edge_total_q + 1'b1 : edge_total_q;
	assign sat_nxt     = edge_sat_q || (sig_edge && edge_total_q == '1);

	// only a gate-closing word needs room in the pipeline
	assign s_tready = adv[0] || !gate_end;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q   <= '0;
			edge_sat_q     <= 1'b0;
			gate_elapsed_q <= '0;
		end else if (in_acc) begin
			if (gate_end) begin
				edge_total_q   <= '0;
				edge_sat_q     <= 1'b0;
				gate_elapsed_q <= '0;
			end else begin
				edge_total_q   <= edge_nxt;
				edge_sat_q     <= sat_nxt;
				gate_elapsed_q <= elapsed_nxt;
			end
		end
	end

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_acc && gate_end;
			end
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	function automatic logic [3:0] bcd_digit(input logic [13:0] v, input logic [13:0] step);
		logic [3:0] d;
		d = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (v >= 14'(k) * step) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

	// s1: capture finished gate
	logic [COUNT_BITS-1:0] cnt_s1;
	logic                  sat_s1;
	logic [7:0]            pre_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cnt_s1 <= edge_nxt;
			sat_s1 <= sat_nxt;
			pre_s1 <= prescale_q;
		end
	end

	// s2: scale
	logic [PW-1:0] prod_s2;
	logic          sat_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			prod_s2 <= PW'(cnt_s1) * PW'(pre_s1);
			sat_s2  <= sat_s1;
		end
	end

	// s3: saturate to 32 bits
	logic [31:0] f_s3;
	logic        ovf_s3;
	logic        ovf_c;

	assign ovf_c = sat_s2 || (prod_s2[PW-1:32] != '0);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			f_s3   <= ovf_c ? 32'hFFFF_FFFF : prod_s2[31:0];
			ovf_s3 <= ovf_c;
		end
	end

	// s4: range select and estimate of f / 1000
	logic [31:0]           f_s4;
	logic                  ovf_s4;
	gfca_pkg::unit_t       unit_s4;
	logic [22:0]           qk_s4;
	logic [54:0]           pk;
	gfca_pkg::unit_t       unit_c;

	assign pk = 55'(f_s3[31:3]) * 55'(gfca_pkg::RECIP125_HI);

	always_comb begin
		if (f_s3 < 32'(gfca_pkg::KILO)) begin
			unit_c = gfca_pkg::UNIT_HZ;
		end else if (f_s3 < 32'(gfca_pkg::MEGA)) begin
			unit_c = gfca_pkg::UNIT_KHZ;
		end else begin
			unit_c = gfca_pkg::UNIT_MHZ;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			f_s4    <= f_s3;
			ovf_s4  <= ovf_s3;
			unit_s4 <= unit_c;
			qk_s4   <= pk[54:32];
		end
	end

	// s5: correct quotient by at most one
	logic [31:0]     f_s5;
	logic            ovf_s5;
	gfca_pkg::unit_t unit_s5;
	logic [22:0]     qk_s5;
	logic [9:0]      rk_s5;
	logic [31:0]     rk_full;
	logic [10:0]     rk_raw;
	logic            rk_fix;

	assign rk_full = f_s4 - 32'(qk_s4) * 32'(gfca_pkg::KILO);
	assign rk_raw  = rk_full[10:0];
	assign rk_fix  = rk_raw >= 11'(gfca_pkg::KILO);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			f_s5    <= f_s4;
			ovf_s5  <= ovf_s4;
			unit_s5 <= unit_s4;
			qk_s5   <= rk_fix ? qk_s4 + 23'd1 : qk_s4;
			rk_s5   <= rk_fix ? 10'(rk_raw - 11'(gfca_pkg::KILO)) : rk_raw[9:0];
		end
	end

	// s6: estimate of (f / 1000) / 1000
	logic [31:0]     f_s6;
	logic            ovf_s6;
	gfca_pkg::unit_t unit_s6;
	logic [22:0]     qk_s6;
	logic [9:0]      rk_s6;
	logic [12:0]     qm_s6;
	logic [37:0]     pm;

	assign pm = 38'(qk_s5[22:3]) * 38'(gfca_pkg::RECIP125_LO);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			f_s6    <= f_s5;
			ovf_s6  <= ovf_s5;
			unit_s6 <= unit_s5;
			qk_s6   <= qk_s5;
			rk_s6   <= rk_s5;
			qm_s6   <= pm[36:24];
		end
	end

	// s7: correct second quotient
	logic [31:0]     f_s7;
	logic            ovf_s7;
	gfca_pkg::unit_t unit_s7;
	logic [22:0]     qk_s7;
	logic [9:0]      rk_s7;
	logic [12:0]     qm_s7;
	logic [9:0]      rm_s7;
	logic [22:0]     rm_full;
	logic [10:0]     rm_raw;
	logic            rm_fix;

	assign rm_full = qk_s6 - 23'(qm_s6) * 23'(gfca_pkg::KILO);
	assign rm_raw  = rm_full[10:0];
	assign rm_fix  = rm_raw >= 11'(gfca_pkg::KILO);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			f_s7    <= f_s6;
			ovf_s7  <= ovf_s6;
			unit_s7 <= unit_s6;
			qk_s7   <= qk_s6;
			rk_s7   <= rk_s6;
			qm_s7   <= rm_fix ? qm_s6 + 13'd1 : qm_s6;
			rm_s7   <= rm_fix ? 10'(rm_raw - 11'(gfca_pkg::KILO)) : rm_raw[9:0];
		end
	end

	// s8: pick whole and fraction for the range
	logic [31:0]     f_s8;
	logic            ovf_s8;
	gfca_pkg::unit_t unit_s8;
	logic [12:0]     whole_s8;
	logic [9:0]      frac_s8;
	logic [12:0]     whole_c;
	logic [9:0]      frac_c;

	always_comb begin
		case (unit_s7)
			gfca_pkg::UNIT_HZ: begin
				whole_c = f_s7[12:0];
				frac_c  = '0;
			end
			gfca_pkg::UNIT_KHZ: begin
				whole_c = qk_s7[12:0];
				frac_c  = rk_s7;
			end
			default: begin
				whole_c = qm_s7;
				frac_c  = rm_s7;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			f_s8     <= f_s7;
			ovf_s8   <= ovf_s7;
			unit_s8  <= unit_s7;
			whole_s8 <= whole_c;
			frac_s8  <= frac_c;
		end
	end

	// s9: thousands of whole, hundreds of fraction
	logic [31:0]     f_s9;
	logic            ovf_s9;
	gfca_pkg::unit_t unit_s9;
	logic [3:0]      wd3_s9;
	logic [9:0]      wrem_s9;
	logic [3:0]      fd2_s9;
	logic [6:0]      frem_s9;
	logic [3:0]      wd3_c;
	logic [3:0]      fd2_c;
	logic [12:0]     wrem_c9;
	logic [9:0]      frem_c9;

	assign wd3_c   = bcd_digit(14'(whole_s8), 14'(gfca_pkg::KILO));
	assign fd2_c   = bcd_digit(14'(frac_s8), 14'd100);
	assign wrem_c9 = whole_s8 - 13'(wd3_c) * 13'(gfca_pkg::KILO);
	assign frem_c9 = frac_s8 - 10'(fd2_c) * 10'd100;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			f_s9    <= f_s8;
			ovf_s9  <= ovf_s8;
			unit_s9 <= unit_s8;
			wd3_s9  <= wd3_c;
			wrem_s9 <= wrem_c9[9:0];
			fd2_s9  <= fd2_c;
			frem_s9 <= frem_c9[6:0];
		end
	end

	// s10: hundreds of whole, tens and ones of fraction
	logic [31:0]     f_s10;
	logic            ovf_s10;
	gfca_pkg::unit_t unit_s10;
	logic [3:0]      wd3_s10;
	logic [3:0]      wd2_s10;
	logic [6:0]      wrem_s10;
	logic [11:0]     fbcd_s10;
	logic [3:0]      wd2_c;
	logic [3:0]      fd1_c;
	logic [9:0]      wrem_c10;
	logic [6:0]      fd0_c;

	assign wd2_c    = bcd_digit(14'(wrem_s9), 14'd100);
	assign fd1_c    = bcd_digit(14'(frem_s9), 14'd10);
	assign wrem_c10 = wrem_s9 - 10'(wd2_c) * 10'd100;
	assign fd0_c    = frem_s9 - 7'(fd1_c) * 7'd10;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			f_s10    <= f_s9;
			ovf_s10  <= ovf_s9;
			unit_s10 <= unit_s9;
			wd3_s10  <= wd3_s9;
			wd2_s10  <= wd2_c;
			wrem_s10 <= wrem_c10[6:0];
			fbcd_s10 <= {fd2_s9, fd1_c, fd0_c[3:0]};
		end
	end

	// s11: output register, tens and ones of whole
	logic [31:0]     f_s11;
	logic            ovf_s11;
	gfca_pkg::unit_t unit_s11;
	logic [15:0]     wbcd_s11;
	logic [11:0]     fbcd_s11;
	logic [3:0]      wd1_c;
	logic [6:0]      wd0_c;

	assign wd1_c = bcd_digit(14'(wrem_s10), 14'd10);
	assign wd0_c = wrem_s10 - 7'(wd1_c) * 7'd10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			f_s11    <= f_s10;
			ovf_s11  <= ovf_s10;
			unit_s11 <= unit_s10;
			wbcd_s11 <= {wd3_s10, wd2_s10, wd1_c, wd0_c[3:0]};
			fbcd_s11 <= fbcd_s10;
		end
	end

	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = {4'b0000, fbcd_s11, wbcd_s11, f_s11};
	assign m_tuser  = {ovf_s11, unit_s11};

	// counters restart after a gate-closing word
	a_gate_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && gate_end) |=> (gate_elapsed_q == '0 && edge_total_q == '0 && !edge_sat_q))
		else $error("counters not cleared at gate end");

	// saturated result carries all-ones frequency
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
		else $error("overflow without saturated frequency");

	// Hz range has no fraction digits
	a_hz_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == gfca_pkg::UNIT_HZ) |-> (m_tdata[59:48] == 12'd0))
		else $error("nonzero fraction in Hz range");

	// input stalls only for a gate-closing word against a blocked first stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (gate_end && vld_q[0] && !adv[0]))
		else $error("unexpected input stall");

endmodule

`default_nettype wire
